>>> hdl/assert_macros.svh
// Assertion helpers, clocked on aclk and quiet while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/sld_pkg.sv
`default_nettype none

package sld_pkg;

    localparam int BUF_DEPTH      = 64;
    localparam int FRAME_OVERHEAD = 7;
    localparam int PTR_W          = $clog2(BUF_DEPTH);
    localparam int CNT_W          = $clog2(BUF_DEPTH + 1);
    localparam int PLEN_W         = 6;
    localparam int PIDX_W         = 6;

    localparam logic [7:0] SYNC1 = 8'h55;
    localparam logic [7:0] SYNC2 = 8'hAA;

    // Byte offsets inside a frame
    localparam int IDX_SYNC1   = 0;
    localparam int IDX_SYNC2   = 1;
    localparam int IDX_VERSION = 2;
    localparam int IDX_COMMAND = 3;
    localparam int IDX_LEN_HI  = 4;
    localparam int IDX_LEN_LO  = 5;
    localparam int IDX_PAYLOAD = 6;

    typedef logic [7:0]        byte_t;
    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [PLEN_W-1:0] plen_t;
    typedef logic [PIDX_W-1:0] pidx_t;

    // Controller to datapath
    typedef struct packed {
        logic wr_en;      // append the accepted word
        logic idx_load;   // set frame offset
        cnt_t idx_val;
        logic idx_inc;
        logic drop_one;   // discard the front byte
        logic drop_frame; // discard the whole declared frame
        logic hi_load;
        logic plen_load;
        logic sum_clr;
        logic sum_add;
        logic ver_load;
        logic cmd_load;
        logic out_load;
    } ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic cnt_short;
        logic is_sync1;
        logic is_sync2;
        logic oversize;
        logic incomplete;
        logic at_check;
        logic sum_match;
        logic pay_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

>>> hdl/sld_ctrl.sv
`default_nettype none

module sld_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire sld_pkg::sts_t sts,
    output sld_pkg::ctl_t      ctl
);
    import sld_pkg::*;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_CHECK = 5'd1;
    localparam logic [4:0] ST_F0W   = 5'd2;
    localparam logic [4:0] ST_F0    = 5'd3;
    localparam logic [4:0] ST_F1W   = 5'd4;
    localparam logic [4:0] ST_F1    = 5'd5;
    localparam logic [4:0] ST_F4W   = 5'd6;
    localparam logic [4:0] ST_F4    = 5'd7;
    localparam logic [4:0] ST_F5W   = 5'd8;
    localparam logic [4:0] ST_F5    = 5'd9;
    localparam logic [4:0] ST_SUMW  = 5'd10;
    localparam logic [4:0] ST_SUM   = 5'd11;
    localparam logic [4:0] ST_VW    = 5'd12;
    localparam logic [4:0] ST_V     = 5'd13;
    localparam logic [4:0] ST_CW    = 5'd14;
    localparam logic [4:0] ST_C     = 5'd15;
    localparam logic [4:0] ST_PW    = 5'd16;
    localparam logic [4:0] ST_P     = 5'd17;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        ctl        = '0;
        s_ready    = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.wr_en  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.cnt_short) begin
                    state_next = ST_IDLE;
                end else begin
                    ctl.idx_load = 1'b1;
                    ctl.idx_val  = CNT_W'(IDX_SYNC1);
                    state_next   = ST_F0W;
                end
            end
            ST_F0W: state_next = ST_F0;
            ST_F0: begin
                if (!sts.is_sync1) begin
                    ctl.drop_one = 1'b1;
                    state_next   = ST_CHECK;
                end else begin
                    ctl.idx_load = 1'b1;
                    ctl.idx_val  = CNT_W'(IDX_SYNC2);
                    state_next   = ST_F1W;
                end
            end
            ST_F1W: state_next = ST_F1;
            ST_F1: begin
                if (!sts.is_sync2) begin
                    ctl.drop_one = 1'b1;
                    state_next   = ST_CHECK;
                end else begin
                    ctl.idx_load = 1'b1;
                    ctl.idx_val  = CNT_W'(IDX_LEN_HI);
                    state_next   = ST_F4W;
                end
            end
            ST_F4W: state_next = ST_F4;
            ST_F4: begin
                ctl.hi_load  = 1'b1;
                ctl.idx_load = 1'b1;
                ctl.idx_val  = CNT_W'(IDX_LEN_LO);
                state_next   = ST_F5W;
            end
            ST_F5W: state_next = ST_F5;
            ST_F5: begin
                if (sts.oversize) begin
                    ctl.drop_one = 1'b1;
                    state_next   = ST_CHECK;
                end else if (sts.incomplete) begin
                    // wait for more words
                    state_next = ST_IDLE;
                end else begin
                    ctl.plen_load = 1'b1;
                    ctl.sum_clr   = 1'b1;
                    ctl.idx_load  = 1'b1;
                    ctl.idx_val   = CNT_W'(IDX_SYNC1);
                    state_next    = ST_SUMW;
                end
            end
            ST_SUMW: begin
                ctl.idx_inc = 1'b1;
                state_next  = ST_SUM;
            end
            ST_SUM: begin
                if (sts.at_check) begin
                    if (sts.sum_match) begin
                        ctl.idx_load = 1'b1;
                        ctl.idx_val  = CNT_W'(IDX_VERSION);
                        state_next   = ST_VW;
                    end else begin
                        ctl.drop_frame = 1'b1;
                        state_next     = ST_CHECK;
                    end
                end else begin
                    ctl.sum_add = 1'b1;
                    ctl.idx_inc = 1'b1;
                end
            end
            ST_VW: state_next = ST_V;
            ST_V: begin
                ctl.ver_load = 1'b1;
                ctl.idx_load = 1'b1;
                ctl.idx_val  = CNT_W'(IDX_COMMAND);
                state_next   = ST_CW;
            end
            ST_CW: state_next = ST_C;
            ST_C: begin
                ctl.cmd_load = 1'b1;
                ctl.idx_load = 1'b1;
                ctl.idx_val  = CNT_W'(IDX_PAYLOAD);
                state_next   = ST_PW;
            end
            ST_PW: state_next = ST_P;
            ST_P: begin
                // hold until the output register is free
                if (sts.out_free) begin
                    ctl.out_load = 1'b1;
                    if (sts.pay_last) begin
                        ctl.drop_frame = 1'b1;
                        state_next     = ST_CHECK;
                    end else begin
                        ctl.idx_inc = 1'b1;
                        state_next  = ST_PW;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/sld_dp.sv
`default_nettype none

module sld_dp (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire sld_pkg::byte_t s_rx_byte,
    output logic                m_valid,
    input  wire logic           m_ready,
    output sld_pkg::byte_t      m_frame_version,
    output sld_pkg::byte_t      m_frame_command,
    output sld_pkg::plen_t      m_payload_length,
    output logic                m_has_payload,
    output sld_pkg::byte_t      m_payload_byte,
    output sld_pkg::pidx_t      m_payload_index,
    output logic                m_last,
    input  wire sld_pkg::ctl_t  ctl,
    output sld_pkg::sts_t       sts
);
    import sld_pkg::*;

    // Circular store: head plus offset, folded back once into range
    function automatic ptr_t wrap_add(input ptr_t base, input cnt_t off);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (s >= (CNT_W+1)'(BUF_DEPTH)) begin
            s = s - (CNT_W+1)'(BUF_DEPTH);
        end
        return ptr_t'(s);
    endfunction

    byte_t mem [BUF_DEPTH];

    ptr_t  head_reg;
    cnt_t  count_reg;
    logic  m_valid_reg;
    cnt_t  idx_reg;
    byte_t rdata_reg;
    logic  hi_nz_reg;
    plen_t plen_reg;
    byte_t sum_reg;
    byte_t ver_reg;
    byte_t cmd_reg;

    byte_t out_ver_reg;
    byte_t out_cmd_reg;
    plen_t out_plen_reg;
    logic  out_has_reg;
    byte_t out_byte_reg;
    pidx_t out_idx_reg;
    logic  out_last_reg;

    ptr_t  tail;
    ptr_t  rd_addr;
    cnt_t  total;
    logic  has_pay;
    logic  store_full;

    assign tail       = wrap_add(head_reg, count_reg);
    assign rd_addr    = wrap_add(head_reg, idx_reg);
    assign total      = CNT_W'(plen_reg) + CNT_W'(FRAME_OVERHEAD);
    assign has_pay    = (plen_reg != '0);
    assign store_full = (count_reg == CNT_W'(BUF_DEPTH));

    always_comb begin
        sts.cnt_short  = (count_reg < CNT_W'(FRAME_OVERHEAD));
        sts.is_sync1   = (rdata_reg == SYNC1);
        sts.is_sync2   = (rdata_reg == SYNC2);
        sts.oversize   = hi_nz_reg || (rdata_reg > 8'(BUF_DEPTH - FRAME_OVERHEAD));
        sts.incomplete = ({1'b0, rdata_reg} + 9'(FRAME_OVERHEAD)) > 9'(count_reg);
        // rdata holds the byte one behind idx while summing
        sts.at_check   = (idx_reg == total);
        sts.sum_match  = (sum_reg == rdata_reg);
        sts.pay_last   = !has_pay || (idx_reg == total - CNT_W'(2));
        sts.out_free   = !m_valid_reg || m_ready;
    end

    // Store and its read port
    always_ff @(posedge aclk) begin
        if (ctl.wr_en && !store_full) begin
            mem[tail] <= s_rx_byte;
        end
        rdata_reg <= mem[rd_addr];
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ctl.wr_en && !store_full) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (ctl.drop_one) begin
                head_reg  <= wrap_add(head_reg, CNT_W'(1));
                count_reg <= count_reg - CNT_W'(1);
            end else if (ctl.drop_frame) begin
                head_reg  <= wrap_add(head_reg, total);
                count_reg <= count_reg - total;
            end
            if (ctl.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Scan registers
    always_ff @(posedge aclk) begin
        if (ctl.idx_load) begin
            idx_reg <= ctl.idx_val;
        end else if (ctl.idx_inc) begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
        if (ctl.hi_load) begin
            hi_nz_reg <= (rdata_reg != '0);
        end
        if (ctl.plen_load) begin
            plen_reg <= rdata_reg[PLEN_W-1:0];
        end
        if (ctl.sum_clr) begin
            sum_reg <= '0;
        end else if (ctl.sum_add) begin
            sum_reg <= sum_reg + rdata_reg;
        end
        if (ctl.ver_load) begin
            ver_reg <= rdata_reg;
        end
        if (ctl.cmd_load) begin
            cmd_reg <= rdata_reg;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            out_ver_reg  <= ver_reg;
            out_cmd_reg  <= cmd_reg;
            out_plen_reg <= plen_reg;
            out_has_reg  <= has_pay;
            out_byte_reg <= has_pay ? rdata_reg : '0;
            out_idx_reg  <= has_pay ? PIDX_W'(idx_reg - CNT_W'(IDX_PAYLOAD)) : '0;
            out_last_reg <= sts.pay_last;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_frame_version  = out_ver_reg;
    assign m_frame_command  = out_cmd_reg;
    assign m_payload_length = out_plen_reg;
    assign m_has_payload    = out_has_reg;
    assign m_payload_byte   = out_byte_reg;
    assign m_payload_index  = out_idx_reg;
    assign m_last           = out_last_reg;

endmodule

`default_nettype wire

>>> hdl/sync_length_sum8_deframer_unit.sv
// Channel   Dir  Handshake          Word
// s_        in   s_valid/s_ready    s_rx_byte
// m_        out  m_valid/m_ready    version, command, length, payload byte, index, last
//
// A received word is appended in IDLE and the store size is tested in CHECK. Each byte dropped at
// the front sends the scan back to CHECK; a frame goes through its header tests (the scan ends
// there while it is incomplete), then its checksum, then its results when it is good, and then
// the front is retested, all through the single registered read port of the 64-byte store.
// s_ready is high only between scans. aresetn is synchronous, active low, and empties the store.
// A stalled m_ready holds the scan at the next result.
`default_nettype none

module sync_length_sum8_deframer_unit (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire sld_pkg::byte_t s_rx_byte,
    output logic                m_valid,
    input  wire logic           m_ready,
    output sld_pkg::byte_t      m_frame_version,
    output sld_pkg::byte_t      m_frame_command,
    output sld_pkg::plen_t      m_payload_length,
    output logic                m_has_payload,
    output sld_pkg::byte_t      m_payload_byte,
    output sld_pkg::pidx_t      m_payload_index,
    output logic                m_last
);
    import sld_pkg::*;

    `include "assert_macros.svh"

    ctl_t ctl;
    sts_t sts;

    sld_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    sld_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_version  (m_frame_version),
        .m_frame_command  (m_frame_command),
        .m_payload_length (m_payload_length),
        .m_has_payload    (m_has_payload),
        .m_payload_byte   (m_payload_byte),
        .m_payload_index  (m_payload_index),
        .m_last           (m_last),
        .ctl              (ctl),
        .sts              (sts)
    );

    `ASSERT_IMPL(a_no_emit_while_ready, s_ready, !ctl.out_load)
    `ASSERT_IMPL(a_load_only_when_free, ctl.out_load, sts.out_free)
    `ASSERT_NEXT(a_busy_after_word, s_valid && s_ready, !s_ready)
    `ASSERT_IMPL(a_single_drop_kind, ctl.drop_one, !ctl.drop_frame && !ctl.wr_en)

endmodule

`default_nettype wire

>>> tb/sync_length_sum8_deframer_unit_checker.sv
`default_nettype none

module sync_length_sum8_deframer_unit_checker (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    input  wire logic           s_ready,
    input  wire sld_pkg::byte_t s_rx_byte,
    input  wire logic           m_valid,
    input  wire logic           m_ready,
    input  wire sld_pkg::byte_t m_frame_version,
    input  wire sld_pkg::byte_t m_frame_command,
    input  wire sld_pkg::plen_t m_payload_length,
    input  wire logic           m_has_payload,
    input  wire sld_pkg::byte_t m_payload_byte,
    input  wire sld_pkg::pidx_t m_payload_index,
    input  wire logic           m_last,
    output int                  fail_count,
    output int                  exp_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import sld_pkg::*;

    typedef struct packed {
        byte_t version;
        byte_t command;
        plen_t length;
        logic  has_payload;
        byte_t data;
        pidx_t index;
        logic  last;
    } frame_word_t;

    byte_t       rx_store [BUF_DEPTH];
    int          rx_fill;
    frame_word_t due_words [$];
    frame_word_t got_word;
    frame_word_t want_word;

    initial begin
        rx_fill    = 0;
        fail_count = 0;
        exp_count  = 0;
    end

    // Append one received byte, then pull every complete good frame off the front.
    task automatic deframe_byte(input byte_t b);
        int          off;
        int          plen;
        int          total;
        int          n;
        int          i;
        byte_t       sum;
        frame_word_t w;
        off = 0;
        if (rx_fill < BUF_DEPTH) begin
            rx_store[rx_fill] = b;
            rx_fill++;
        end
        while (rx_fill - off >= FRAME_OVERHEAD) begin
            if (rx_store[off + IDX_SYNC1] != SYNC1 || rx_store[off + IDX_SYNC2] != SYNC2) begin
                off++;
                continue;
            end
            plen  = int'(rx_store[off + IDX_LEN_HI]) * 256 + int'(rx_store[off + IDX_LEN_LO]);
            total = plen + FRAME_OVERHEAD;
            if (total > BUF_DEPTH) begin
                off++;
                continue;
            end
            // incomplete frame: hold the bytes for more input
            if (off + total > rx_fill)
                break;
            sum = '0;
            for (i = 0; i + 1 < total; i++)
                sum = sum + rx_store[off + i];
            if (sum == rx_store[off + total - 1]) begin
                n = (plen == 0) ? 1 : plen;
                for (i = 0; i < n; i++) begin
                    w.version     = rx_store[off + IDX_VERSION];
                    w.command     = rx_store[off + IDX_COMMAND];
                    w.length      = plen_t'(plen);
                    w.has_payload = (plen != 0);
                    w.data        = (plen == 0) ? byte_t'(0) : rx_store[off + IDX_PAYLOAD + i];
                    w.index       = (plen == 0) ? pidx_t'(0) : pidx_t'(i);
                    w.last        = (i + 1 == n);
                    due_words.push_back(w);
                end
            end
            off += total;
        end
        if (off > 0) begin
            for (i = 0; i < rx_fill - off; i++)
                rx_store[i] = rx_store[i + off];
            rx_fill -= off;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            rx_fill = 0;
            due_words.delete();
        end else begin
            if (m_valid && m_ready) begin
                got_word.version     = m_frame_version;
                got_word.command     = m_frame_command;
                got_word.length      = m_payload_length;
                got_word.has_payload = m_has_payload;
                got_word.data        = m_payload_byte;
                got_word.index       = m_payload_index;
                got_word.last        = m_last;
                if (due_words.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"%0t: unexpected word: ver %h cmd %h len %0d has %b",
                                  " byte %h idx %0d last %b"},
                                 $realtime, got_word.version, got_word.command, got_word.length,
                                 got_word.has_payload, got_word.data, got_word.index,
                                 got_word.last);
                end else begin
                    want_word = due_words.pop_front();
                    if (got_word !== want_word) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: word mismatch", $realtime);
                            $display("  exp: ver %h cmd %h len %0d has %b byte %h idx %0d last %b",
                                     want_word.version, want_word.command, want_word.length,
                                     want_word.has_payload, want_word.data, want_word.index,
                                     want_word.last);
                            $display("  got: ver %h cmd %h len %0d has %b byte %h idx %0d last %b",
                                     got_word.version, got_word.command, got_word.length,
                                     got_word.has_payload, got_word.data, got_word.index,
                                     got_word.last);
                        end
                    end
                end
            end
            if (s_valid && s_ready)
                deframe_byte(s_rx_byte);
        end
        exp_count = due_words.size();
    end

endmodule

`default_nettype wire

>>> tb/sync_length_sum8_deframer_unit_tb.sv
`default_nettype none

module sync_length_sum8_deframer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sld_pkg::*;

    logic   aclk      = 1'b0;
    logic   aresetn   = 1'b0;
    logic   s_valid   = 1'b0;
    logic   s_ready;
    byte_t  s_rx_byte = '0;
    logic   m_valid;
    logic   m_ready   = 1'b0;
    byte_t  m_frame_version;
    byte_t  m_frame_command;
    plen_t  m_payload_length;
    logic   m_has_payload;
    byte_t  m_payload_byte;
    pidx_t  m_payload_index;
    logic   m_last;

    int     fail_count;
    int     exp_count;

    int     s_idle_pct = 0;
    int     m_idle_pct = 0;
    logic   hold_start = 1'b0;
    logic   hold_done  = 1'b0;
    int     hold_left  = 0;
    int     bytes_sent = 0;

    always #5 aclk = ~aclk;

    sync_length_sum8_deframer_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_version  (m_frame_version),
        .m_frame_command  (m_frame_command),
        .m_payload_length (m_payload_length),
        .m_has_payload    (m_has_payload),
        .m_payload_byte   (m_payload_byte),
        .m_payload_index  (m_payload_index),
        .m_last           (m_last)
    );

    sync_length_sum8_deframer_unit_checker chk (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_version  (m_frame_version),
        .m_frame_command  (m_frame_command),
        .m_payload_length (m_payload_length),
        .m_has_payload    (m_has_payload),
        .m_payload_byte   (m_payload_byte),
        .m_payload_index  (m_payload_index),
        .m_last           (m_last),
        .fail_count       (fail_count),
        .exp_count        (exp_count)
    );

    // Receiver: random stalls, plus one long hold-off to back the block up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_start && !hold_done) begin
            m_ready   <= 1'b0;
            hold_left <= 600;
            hold_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    task automatic push_rx_byte(input byte_t b);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    // Send the first cut bytes of a frame with random payload.
    task automatic push_frame(input byte_t ver, input byte_t cmd, input int plen,
                              input bit bad_sum, input int cut);
        byte_t fr [$];
        byte_t sum;
        int    i;
        fr.push_back(SYNC1);
        fr.push_back(SYNC2);
        fr.push_back(ver);
        fr.push_back(cmd);
        fr.push_back(8'h00);
        fr.push_back(byte_t'(plen));
        for (i = 0; i < plen; i++)
            fr.push_back(byte_t'($urandom_range(255)));
        sum = '0;
        for (i = 0; i < fr.size(); i++)
            sum = sum + fr[i];
        if (bad_sum)
            sum = sum ^ byte_t'($urandom_range(1, 255));
        fr.push_back(sum);
        for (i = 0; i < cut && i < fr.size(); i++)
            push_rx_byte(fr[i]);
    endtask

    task automatic push_traffic(input int target);
        int    stop_at;
        int    r;
        int    plen;
        int    k;
        byte_t b;
        stop_at = bytes_sent + target;
        while (bytes_sent < stop_at) begin
            r = $urandom_range(99);
            if (r < 60) begin
                plen = ($urandom_range(99) < 85) ? $urandom_range(8) : $urandom_range(9, 30);
                push_frame(byte_t'($urandom_range(255)), byte_t'($urandom_range(255)), plen,
                           1'b0, 1000);
            end else if (r < 70) begin
                push_frame(byte_t'($urandom_range(255)), byte_t'($urandom_range(255)),
                           $urandom_range(8), 1'b1, 1000);
            end else if (r < 80) begin
                for (k = $urandom_range(1, 4); k > 0; k--) begin
                    b = ($urandom_range(3) == 0) ? SYNC1 : byte_t'($urandom_range(255));
                    push_rx_byte(b);
                end
            end else if (r < 86) begin
                push_rx_byte(SYNC1);
                b = byte_t'($urandom_range(255));
                push_rx_byte((b == SYNC2) ? 8'h00 : b);
            end else if (r < 93) begin
                // oversize declared length
                push_rx_byte(SYNC1);
                push_rx_byte(SYNC2);
                push_rx_byte(byte_t'($urandom_range(255)));
                push_rx_byte(byte_t'($urandom_range(255)));
                if ($urandom_range(1)) begin
                    push_rx_byte(byte_t'($urandom_range(1, 255)));
                    push_rx_byte(byte_t'($urandom_range(255)));
                end else begin
                    push_rx_byte(8'h00);
                    push_rx_byte(byte_t'($urandom_range(BUF_DEPTH - FRAME_OVERHEAD + 1, 255)));
                end
            end else begin
                plen = $urandom_range(8);
                push_frame(byte_t'($urandom_range(255)), byte_t'($urandom_range(255)), plen,
                           1'b0, $urandom_range(1, plen + FRAME_OVERHEAD - 1));
            end
        end
    endtask

    // Drop valid and wait until every predicted word has come out.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (exp_count != 0);
        @(posedge aclk);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn    <= 1'b1;
        s_idle_pct <= 22;
        m_idle_pct <= 81;
        @(posedge aclk);

        // bad first sync, bad second sync, oversize header
        push_rx_byte(8'h00);
        push_rx_byte(SYNC1);
        push_rx_byte(8'h12);
        push_rx_byte(SYNC1);
        push_rx_byte(SYNC2);
        push_rx_byte(8'h00);
        push_rx_byte(8'h00);
        push_rx_byte(8'h00);
        push_rx_byte(8'h3A);
        // empty payload, good and with a bad checksum
        push_frame(8'hFF, 8'h00, 0, 1'b0, 1000);
        push_frame(8'h01, 8'h02, 0, 1'b1, 1000);
        push_traffic(35);
        wait_drained();

        s_idle_pct <= 81;
        m_idle_pct <= 22;
        push_traffic(50);
        wait_drained();

        s_idle_pct <= 0;
        m_idle_pct <= 0;
        hold_start <= 1'b1;
        push_frame(8'h5A, 8'hC3, 3, 1'b0, 1000);
        push_frame(8'hA5, 8'h3C, 2, 1'b0, 1000);
        push_traffic(15);
        // largest frame that fits the store
        push_frame(8'h80, 8'h7F, BUF_DEPTH - FRAME_OVERHEAD, 1'b0, 1000);
        push_traffic(25);
        wait_drained();

        repeat (1000) @(posedge aclk);
        @(negedge aclk);
        if (fail_count == 0 && exp_count == 0) begin
            $display("sync_length_sum8_deframer_unit verification clean");
        end else begin
            $display("sync_length_sum8_deframer_unit verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("sync_length_sum8_deframer_unit verification failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> sync_length_sum8_deframer_unit.f
+incdir+hdl
hdl/sld_pkg.sv
hdl/sld_ctrl.sv
hdl/sld_dp.sv
hdl/sync_length_sum8_deframer_unit.sv
tb/sync_length_sum8_deframer_unit_checker.sv
tb/sync_length_sum8_deframer_unit_tb.sv
